[rtl/prol_pkg.sv]
// Shared types, widths and codes for the PI regulator with overcurrent lockout.
package prol_pkg;

   // Fraction bits of the fixed-point control law.
   localparam int FracBits = 24;

   // Field widths.
   localparam int SampleW = 16;
   localparam int GainW = 16;
   localparam int IntegW = 31;
   localparam int LimitW = 15;
   localparam int TicksW = 24;
   localparam int PwmW = 16;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 31;

   // Arithmetic widths: error, gain products, integrator sum, positive sum magnitude.
   localparam int ErrW = SampleW + 1;
   localparam int ProdW = 2 * ErrW;
   localparam int SumW = ProdW + 1;
   localparam int MagW = SumW - 2;
   localparam int ScaleW = MagW + PwmW;
   localparam int ShW = ScaleW - FracBits;

   // Register indexes of the configuration port.
   localparam logic [CsrAddrW-1:0] RegSetpoint = 3'd0;
   localparam logic [CsrAddrW-1:0] RegKpGain = 3'd1;
   localparam logic [CsrAddrW-1:0] RegKiGain = 3'd2;
   localparam logic [CsrAddrW-1:0] RegIntegMax = 3'd3;
   localparam logic [CsrAddrW-1:0] RegCurrentLimit = 3'd4;
   localparam logic [CsrAddrW-1:0] RegLockoutTicks = 3'd5;
   localparam logic [CsrAddrW-1:0] RegPwmFull = 3'd6;

   // Reset values of the registers.
   localparam logic [GainW-1:0] SetpointRst = 16'd1600;
   localparam logic [GainW-1:0] KpGainRst = 16'd1573;
   localparam logic [GainW-1:0] KiGainRst = 16'd52;
   localparam logic [IntegW-1:0] IntegMaxRst = 31'd1677721600;
   localparam logic [LimitW-1:0] CurrentLimitRst = 15'd27306;
   localparam logic [TicksW-1:0] LockoutTicksRst = 24'd50000;
   localparam logic [PwmW-1:0] PwmFullRst = 16'd959;

   // Current register contents.
   typedef struct packed {
      logic [GainW-1:0]  setpoint;
      logic [GainW-1:0]  kp_gain;
      logic [GainW-1:0]  ki_gain;
      logic [IntegW-1:0] integ_max;
      logic [LimitW-1:0] current_limit;
      logic [TicksW-1:0] lockout_ticks;
      logic [PwmW-1:0]   pwm_full;
   } cfg_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_CLAMP,
      S_SCALE,
      S_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic check;
      logic clamp;
      logic scale;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic locked;
      logic out_free;
   } status_type;

endpackage

[rtl/prol_csr.sv]
// Configuration register file with reset values and index decode.
module prol_csr
   import prol_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [CsrDataW-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode one write; unknown indexes leave everything unchanged.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            RegSetpoint:     cfg_in.setpoint = csr_wdata[GainW-1:0];
            RegKpGain:       cfg_in.kp_gain = csr_wdata[GainW-1:0];
            RegKiGain:       cfg_in.ki_gain = csr_wdata[GainW-1:0];
            RegIntegMax:     cfg_in.integ_max = csr_wdata[IntegW-1:0];
            RegCurrentLimit: cfg_in.current_limit = csr_wdata[LimitW-1:0];
            RegLockoutTicks: cfg_in.lockout_ticks = csr_wdata[TicksW-1:0];
            RegPwmFull:      cfg_in.pwm_full = csr_wdata[PwmW-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint <= SetpointRst;
         cfg_ff.kp_gain <= KpGainRst;
         cfg_ff.ki_gain <= KiGainRst;
         cfg_ff.integ_max <= IntegMaxRst;
         cfg_ff.current_limit <= CurrentLimitRst;
         cfg_ff.lockout_ticks <= LockoutTicksRst;
         cfg_ff.pwm_full <= PwmFullRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/prol_ctrl.sv]
// Controller state machine that sequences one control tick through the datapath.
module prol_ctrl
   import prol_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_CHECK;
         S_CHECK: state_in = status.locked ? S_OUT : S_CLAMP;
         S_CLAMP: state_in = S_SCALE;
         S_SCALE: state_in = S_OUT;
         S_OUT:   if (status.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.capture = req_tvalid;
         end
         S_CHECK: cmd.check = 1'b1;
         S_CLAMP: cmd.clamp = 1'b1;
         S_SCALE: cmd.scale = 1'b1;
         S_OUT:   cmd.load_out = status.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted beat is followed by a cycle with the input closed.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted twice in a row");

   // A tick found locked at the trip check goes on to the output state, skipping clamp and scale.
   assert property (@(posedge clock) disable iff (reset)
      cmd.check && status.locked |=> state_ff == S_OUT)
      else $error("lockout tick did not go to output");

endmodule

[rtl/prol_dp.sv]
// Datapath: trip check, lockout counter, PI law, scaling and the output register.
module prol_dp
   import prol_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [SampleW-1:0] current_raw,
   input  logic [SampleW-1:0] voltage_raw,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [PwmW-1:0]    pulse_width,
   output logic               in_lockout
);

   logic signed [SampleW-1:0] cur_ff;
   logic signed [ErrW-1:0]    err_ff;
   logic                      lock_flag_ff;
   logic [TicksW-1:0]         lock_cnt_ff;
   logic                      lock_path_ff;
   logic signed [ProdW-1:0]   prop_ff;
   logic signed [ProdW-1:0]   kierr_ff;
   logic [IntegW-1:0]         integ_ff;
   logic signed [SumW-1:0]    sum_ff;
   logic                      pos_ff;
   logic [ScaleW-1:0]         prod_ff;
   logic                      rsp_valid_ff;
   logic [PwmW-1:0]           pulse_ff;
   logic                      lock_out_ff;

   logic                      trip;
   logic                      locked;
   logic signed [ErrW-1:0]    kp_s;
   logic signed [ErrW-1:0]    ki_s;
   logic signed [ProdW-1:0]   prop_w;
   logic signed [ProdW-1:0]   kierr_w;
   logic signed [SumW-1:0]    integ_w;
   logic signed [SumW-1:0]    imax_s;
   logic [IntegW-1:0]         clamped;
   logic signed [SumW-1:0]    sum_w;
   logic [ScaleW-1:0]         prod_w;
   logic [ShW-1:0]            scaled;
   logic [PwmW-1:0]           sat;

   // Trip test against the limit, signed compare.
   assign trip = cur_ff > $signed({1'b0, cfg.current_limit});
   assign locked = lock_flag_ff | trip;

   // Gain products, one multiplier each.
   assign kp_s = $signed({1'b0, cfg.kp_gain});
   assign ki_s = $signed({1'b0, cfg.ki_gain});
   assign prop_w = kp_s * err_ff;
   assign kierr_w = ki_s * err_ff;

   // Integrator update clamped to zero and the upper limit.
   assign integ_w = SumW'(kierr_ff) + SumW'($signed({1'b0, integ_ff}));
   assign imax_s = SumW'({1'b0, cfg.integ_max});
   always_comb begin
      if (integ_w > imax_s) begin
         clamped = cfg.integ_max;
      end else if (integ_w[SumW-1]) begin
         clamped = '0;
      end else begin
         clamped = integ_w[IntegW-1:0];
      end
   end
   assign sum_w = SumW'(prop_ff) + SumW'($signed({1'b0, clamped}));

   // Scale the positive sum to a pulse width and saturate.
   assign prod_w = ScaleW'(sum_ff[MagW-1:0]) * ScaleW'(cfg.pwm_full);
   assign scaled = prod_ff[ScaleW-1:FracBits];
   always_comb begin
      if (!pos_ff) begin
         sat = '0;
      end else if (scaled > ShW'(cfg.pwm_full)) begin
         sat = cfg.pwm_full;
      end else begin
         sat = scaled[PwmW-1:0];
      end
   end

   assign status.locked = locked;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // Control state: lockout flag, counter, integrator and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         lock_flag_ff <= 1'b0;
         lock_cnt_ff <= '0;
         integ_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.check && locked) begin
            if (lock_cnt_ff < cfg.lockout_ticks) begin
               lock_cnt_ff <= lock_cnt_ff + 1'b1;
               lock_flag_ff <= 1'b1;
            end else begin
               lock_cnt_ff <= '0;
               lock_flag_ff <= 1'b0;
            end
         end
         if (cmd.clamp) begin
            integ_ff <= clamped;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_ff <= $signed(current_raw);
         err_ff <= $signed({1'b0, cfg.setpoint}) - $signed({1'b0, voltage_raw});
      end
      if (cmd.check) begin
         lock_path_ff <= locked;
         prop_ff <= prop_w;
         kierr_ff <= kierr_w;
      end
      if (cmd.clamp) begin
         sum_ff <= sum_w;
      end
      if (cmd.scale) begin
         pos_ff <= !sum_ff[SumW-1] && (sum_ff != '0);
         prod_ff <= prod_w;
      end
      if (cmd.load_out) begin
         pulse_ff <= lock_path_ff ? '0 : sat;
         lock_out_ff <= lock_path_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign pulse_width = pulse_ff;
   assign in_lockout = lock_out_ff;

   // A lockout beat always carries a zero pulse width.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && lock_out_ff |-> pulse_ff == '0)
      else $error("nonzero pulse width during lockout");

   // A freshly loaded pulse width never exceeds the ceiling.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> pulse_ff <= cfg.pwm_full)
      else $error("pulse width above ceiling");

   // The lockout counter runs only while the flag is set.
   assert property (@(posedge clock) disable iff (reset)
      lock_cnt_ff != '0 |-> lock_flag_ff)
      else $error("lockout counter running without flag");

endmodule

[rtl/pi_regulator_overcurrent_lockout.sv]
// Top level of the PI bus-voltage regulator with overcurrent lockout.
//
//   Channel  Direction  Contents
//   req_     in         tdata: current_raw [15:0], voltage_raw [31:16]
//   rsp_     out        tdata: pulse_width [15:0]; tuser: in_lockout
//   csr_     in         write enable, 3-bit register index, 31-bit data
//
// A tick walks from accept through the trip check, integrator clamp and scaling
// multiply in turn to the loaded result; a lockout tick goes from the trip check
// straight to the load. A new beat is taken only once the controller is back in
// idle after the load. Reset is synchronous and returns registers to
// their defaults, clears the integrator and lockout state and empties the output.
// A stalled result holds in the output register; the next tick waits finished in
// the datapath with the input closed until that register is free.
module pi_regulator_overcurrent_lockout
   import prol_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2*SampleW-1:0]  req_tdata,   // current_raw, voltage_raw
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PwmW-1:0]       rsp_tdata,   // pulse_width
   output logic                  rsp_tuser,   // in_lockout
   input  logic                  csr_we,
   input  logic [CsrAddrW-1:0]   csr_addr,
   input  logic [CsrDataW-1:0]   csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   prol_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   prol_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   prol_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .current_raw (req_tdata[SampleW-1:0]),
      .voltage_raw (req_tdata[2*SampleW-1:SampleW]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .pulse_width (rsp_tdata),
      .in_lockout  (rsp_tuser)
   );

endmodule
